[hdl/ost_pkg.sv]
// ----------------------------------------------------------------------------
// ost_pkg
// Shared constants, codes and control structs of the ordered set table.
// ----------------------------------------------------------------------------
package ost_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 7;
  localparam int IDX_W    = 6;
  localparam int DATA_W   = 32;

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_REMOVE   = 2'd1,
    MODE_CONTAINS = 2'd2,
    MODE_READ     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic scan;
    logic shift;
    logic rd_issue;
    logic rd_capture;
    logic apply;
    logic load_out;
  } ost_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_is_read;
    logic req_remove;
    logic found;
    logic scan_done;
    logic shift_done;
    logic out_full;
  } ost_stat_t;

endpackage

[hdl/ost_ifs.sv]
// ----------------------------------------------------------------------------
// ost channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ost_req_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic signed [ost_pkg::DATA_W-1:0] value;
  logic [ost_pkg::IDX_W-1:0]    index;

  modport source (output valid, mode, value, index, input ready);
  modport sink   (input valid, mode, value, index, output ready);
endinterface

interface ost_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         hit;
  logic [1:0]                   status;
  logic signed [ost_pkg::DATA_W-1:0] read_value;
  logic [ost_pkg::CNT_W-1:0]    count;

  modport source (output valid, hit, status, read_value, count, input ready);
  modport sink   (input valid, hit, status, read_value, count, output ready);
endinterface

[hdl/ost_ram.sv]
// ----------------------------------------------------------------------------
// ost_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ost_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[hdl/ost_datapath.sv]
// ----------------------------------------------------------------------------
// ost_datapath
// Request latch, entry memory, scan/shift pointers, count and result word.
// ----------------------------------------------------------------------------
module ost_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  ost_pkg::ost_cmd_t   cmd,
  output ost_pkg::ost_stat_t  stat,
  ost_req_if.sink             in_ch,
  ost_rsp_if.source           out_ch
);

  logic [1:0]                       req_mode_r, req_mode_nxt;
  logic [ost_pkg::DATA_W-1:0]       req_value_r, req_value_nxt;
  logic [ost_pkg::IDX_W-1:0]        req_index_r, req_index_nxt;
  logic [ost_pkg::CNT_W-1:0]        count_r, count_nxt;
  logic [ost_pkg::CNT_W-1:0]        ptr_r, ptr_nxt;
  logic [ost_pkg::ADDR_W-1:0]       cmp_r, cmp_nxt;
  logic                             rd_pend_r, rd_pend_nxt;
  logic                             hit_r, hit_nxt;
  ost_pkg::status_t                 res_status_r, res_status_nxt;
  logic [ost_pkg::DATA_W-1:0]       res_rd_r, res_rd_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_hit_r;
  logic [1:0]                       out_status_r;
  logic [ost_pkg::DATA_W-1:0]       out_rd_r;
  logic [ost_pkg::CNT_W-1:0]        out_count_r;

  logic                             ram_we, ram_re;
  logic [ost_pkg::ADDR_W-1:0]       ram_waddr, ram_raddr;
  logic [ost_pkg::DATA_W-1:0]       ram_wdata, ram_rdata;
  logic                             found, ptr_lt, idx_ok;
  ost_pkg::mode_t                   mode;

  ost_ram #(
    .WIDTH (ost_pkg::DATA_W),
    .DEPTH (ost_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mode   = ost_pkg::mode_t'(req_mode_r);
  assign found  = rd_pend_r && (ram_rdata == req_value_r);
  assign ptr_lt = ptr_r < count_r;
  assign idx_ok = ost_pkg::CNT_W'(req_index_r) < count_r;

  always_comb begin
    stat.in_is_read = (ost_pkg::mode_t'(in_ch.mode) == ost_pkg::MODE_READ);
    stat.req_remove = (mode == ost_pkg::MODE_REMOVE);
    stat.found      = found;
    stat.scan_done  = !found && !ptr_lt && !rd_pend_r;
    stat.shift_done = !rd_pend_r && !ptr_lt;
    stat.out_full   = out_valid_r;
  end

  always_comb begin
    req_mode_nxt   = req_mode_r;
    req_value_nxt  = req_value_r;
    req_index_nxt  = req_index_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    cmp_nxt        = cmp_r;
    rd_pend_nxt    = rd_pend_r;
    hit_nxt        = hit_r;
    res_status_nxt = res_status_r;
    res_rd_nxt     = res_rd_r;
    ram_we         = 1'b0;
    ram_waddr      = cmp_r - ost_pkg::ADDR_W'(1);
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = ptr_r[ost_pkg::ADDR_W-1:0];

    if (cmd.accept) begin
      req_mode_nxt  = in_ch.mode;
      req_value_nxt = in_ch.value;
      req_index_nxt = in_ch.index;
      ptr_nxt       = '0;
      rd_pend_nxt   = 1'b0;
      hit_nxt       = 1'b0;
    end

    // search: one read issued per cycle, compare in the following cycle
    if (cmd.scan) begin
      if (found) begin
        hit_nxt     = 1'b1;
        ptr_nxt     = ost_pkg::CNT_W'(cmp_r) + ost_pkg::CNT_W'(1);
        rd_pend_nxt = 1'b0;
      end else begin
        ram_re      = ptr_lt;
        rd_pend_nxt = ptr_lt;
        cmp_nxt     = ptr_r[ost_pkg::ADDR_W-1:0];
        if (ptr_lt) begin
          ptr_nxt = ptr_r + ost_pkg::CNT_W'(1);
        end
      end
    end

    // shift: entry read last cycle moves one place down
    if (cmd.shift) begin
      ram_we      = rd_pend_r;
      ram_re      = ptr_lt;
      rd_pend_nxt = ptr_lt;
      cmp_nxt     = ptr_r[ost_pkg::ADDR_W-1:0];
      if (ptr_lt) begin
        ptr_nxt = ptr_r + ost_pkg::CNT_W'(1);
      end
    end

    if (cmd.rd_issue) begin
      ram_re    = 1'b1;
      ram_raddr = req_index_r[ost_pkg::ADDR_W-1:0];
    end

    if (cmd.rd_capture) begin
      hit_nxt = 1'b0;
      if (idx_ok) begin
        res_status_nxt = ost_pkg::ST_DONE;
        res_rd_nxt     = ram_rdata;
      end else begin
        res_status_nxt = ost_pkg::ST_MISS;
        res_rd_nxt     = '0;
      end
    end

    if (cmd.apply) begin
      res_rd_nxt = '0;
      case (mode)
        ost_pkg::MODE_ADD: begin
          if (hit_r) begin
            res_status_nxt = ost_pkg::ST_DUP;
          end else if (count_r >= ost_pkg::CNT_W'(ost_pkg::CAPACITY)) begin
            res_status_nxt = ost_pkg::ST_FULL;
          end else begin
            res_status_nxt = ost_pkg::ST_DONE;
            ram_we         = 1'b1;
            ram_waddr      = count_r[ost_pkg::ADDR_W-1:0];
            ram_wdata      = req_value_r;
            count_nxt      = count_r + ost_pkg::CNT_W'(1);
          end
        end
        ost_pkg::MODE_REMOVE: begin
          if (hit_r) begin
            res_status_nxt = ost_pkg::ST_DONE;
            count_nxt      = count_r - ost_pkg::CNT_W'(1);
          end else begin
            res_status_nxt = ost_pkg::ST_MISS;
          end
        end
        default: begin
          res_status_nxt = hit_r ? ost_pkg::ST_DONE : ost_pkg::ST_MISS;
        end
      endcase
    end

    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_mode_r   <= req_mode_nxt;
    req_value_r  <= req_value_nxt;
    req_index_r  <= req_index_nxt;
    ptr_r        <= ptr_nxt;
    cmp_r        <= cmp_nxt;
    hit_r        <= hit_nxt;
    res_status_r <= res_status_nxt;
    res_rd_r     <= res_rd_nxt;
    if (cmd.load_out) begin
      out_hit_r    <= hit_r;
      out_status_r <= res_status_r;
      out_rd_r     <= res_rd_r;
      out_count_r  <= count_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.count      = out_count_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= ost_pkg::CNT_W'(ost_pkg::CAPACITY))
    else $error("stored count above capacity");

  a_shift_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && rd_pend_r) |-> (cmp_r != '0))
    else $error("shift write below entry zero");

  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.apply && mode == ost_pkg::MODE_REMOVE && hit_r)
      |=> (count_r == $past(count_r) - ost_pkg::CNT_W'(1)))
    else $error("remove hit did not shrink the table");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ch.ready))
    else $error("result word overwritten while pending");
`endif

endmodule

[hdl/ost_ctrl.sv]
// ----------------------------------------------------------------------------
// ost_ctrl
// Sequencer: search, shift, read, apply and result hand-off for one request.
// ----------------------------------------------------------------------------
module ost_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  input  ost_pkg::ost_stat_t  stat,
  output logic                in_ready,
  output ost_pkg::ost_cmd_t   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_RD_ISSUE,
    S_RD_WAIT,
    S_APPLY,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.in_is_read ? S_RD_ISSUE : S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.scan = 1'b1;
        if (stat.found && stat.req_remove) begin
          state_nxt = S_SHIFT;
        end else if (stat.found || stat.scan_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          state_nxt = S_APPLY;
        end
      end
      S_RD_ISSUE: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RD_WAIT;
      end
      S_RD_WAIT: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_APPLY: begin
        cmd.apply = 1'b1;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        // wait for the result register to free up
        if (!stat.out_full || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTHESIS
  a_shift_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> stat.req_remove)
    else $error("shift entered for a request other than remove");

  a_load_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle after result");
`endif

endmodule

[hdl/ordered_set_table.sv]
// ----------------------------------------------------------------------------
// ordered_set_table
// Set of distinct 32-bit values in insertion order: add, remove, contains,
// read by index, capacity of 64 entries.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          word
//  in_ch     in   valid/ready        mode, value, index
//  out_ch    out  valid/ready        hit, status, read_value, count
//
//  read passes the issue and wait states to the result register; add, contains
//  and remove scan the stored entries and remove also shifts those behind the
//  hit, paced by the single read port of the entry memory (one entry read per
//  cycle).
//  synchronous active-low reset clears the count; entries need no clearing.
//  one request in flight; the next is taken while a result waits on out_ch.
module ordered_set_table (
  input  logic      clk,
  input  logic      rst_n,
  ost_req_if.sink   in_ch,
  ost_rsp_if.source out_ch
);

  ost_pkg::ost_cmd_t  cmd;
  ost_pkg::ost_stat_t stat;
  logic               in_ready;

  ost_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .in_ready  (in_ready),
    .cmd       (cmd)
  );

  ost_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .stat   (stat),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule

[bench/ordered_set_table_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_set_table_tb
// Drives add, remove, contains and read words into the ordered set table and
// checks every response against a predicted copy of the table. Directed
// corner words come first. Random traffic follows in four phases of sender
// idling and receiver stalling and alternates fill and drain stretches, so that the table reaches full and
// empty. One long receiver hold-off backs the block up onto its input.
// ----------------------------------------------------------------------------
module ordered_set_table_tb;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int ITEMS_PER_PH = 438;
  localparam int SEG_LEN      = 120;
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  typedef logic signed [ost_pkg::DATA_W-1:0] word_val_t;

  typedef struct {
    logic                      hit;
    ost_pkg::status_t          status;
    word_val_t                 read_value;
    logic [ost_pkg::CNT_W-1:0] count;
  } rsp_word_t;

  class set_table_scoreboard;
    word_val_t   slots[ost_pkg::CAPACITY];
    int unsigned n_stored;
    rsp_word_t   pending[$];
    int unsigned n_errors;

    function new();
      n_stored = 0;
      n_errors = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function int locate(word_val_t v);
      for (int i = 0; i < n_stored; i++)
        if (slots[i] === v) return i;
      return -1;
    endfunction

    function word_val_t stored_at(int unsigned i);
      return slots[i];
    endfunction

    function int unsigned pending_count();
      return pending.size();
    endfunction

    // accepted request word: update the table copy and queue its response
    function void note_request(ost_pkg::mode_t m, word_val_t v,
                               logic [ost_pkg::IDX_W-1:0] idx);
      rsp_word_t r;
      int        pos;
      r.hit        = 1'b0;
      r.status     = ost_pkg::ST_DONE;
      r.read_value = '0;
      if (m == ost_pkg::MODE_READ) begin
        if (idx < n_stored) r.read_value = slots[idx];
        else r.status = ost_pkg::ST_MISS;
      end else begin
        pos   = locate(v);
        r.hit = (pos >= 0);
        case (m)
          ost_pkg::MODE_ADD: begin
            if (pos >= 0) r.status = ost_pkg::ST_DUP;
            else if (n_stored >= ost_pkg::CAPACITY) r.status = ost_pkg::ST_FULL;
            else begin
              slots[n_stored] = v;
              n_stored++;
            end
          end
          ost_pkg::MODE_REMOVE: begin
            if (pos < 0) r.status = ost_pkg::ST_MISS;
            else begin
              for (int i = pos; i + 1 < n_stored; i++) slots[i] = slots[i + 1];
              n_stored--;
            end
          end
          default: begin
            if (pos < 0) r.status = ost_pkg::ST_MISS;
          end
        endcase
      end
      r.count = n_stored[ost_pkg::CNT_W-1:0];
      pending.push_back(r);
    endfunction

    function void check_response(logic hit, logic [1:0] status, word_val_t rv,
                                 logic [ost_pkg::CNT_W-1:0] cnt);
      rsp_word_t e;
      if (pending.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("unexpected response: hit %0d status %0d read_value %0d count %0d",
                   hit, status, rv, cnt);
        return;
      end
      e = pending.pop_front();
      if (hit !== e.hit || status !== e.status || rv !== e.read_value ||
          cnt !== e.count) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
          $display("mismatch: expected hit %0d status %0d read_value %0d count %0d",
                   e.hit, e.status, e.read_value, e.count);
          $display("          got hit %0d status %0d read_value %0d count %0d",
                   hit, status, rv, cnt);
        end
      end
    endfunction

    function void close_out();
      if (pending.size() != 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0d responses never arrived", pending.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  ost_req_if req_ch ();
  ost_rsp_if rsp_ch ();

  ordered_set_table i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_ch),
    .out_ch (rsp_ch)
  );

  set_table_scoreboard sb;

  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  int unsigned hold_left;
  int unsigned cycle_count;

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready)
        sb.note_request(ost_pkg::mode_t'(req_ch.mode), req_ch.value, req_ch.index);
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.hit, rsp_ch.status, rsp_ch.read_value, rsp_ch.count);
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    rsp_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (!rst_n) begin
        rsp_ch.ready = 1'b0;
      end else if (hold_left > 0) begin
        rsp_ch.ready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        rsp_ch.ready = 1'b0;
      end else begin
        rsp_ch.ready = ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // called just after a falling edge; returns just after a falling edge, once the word has been taken
  task automatic send_word(ost_pkg::mode_t m, word_val_t v,
                           logic [ost_pkg::IDX_W-1:0] idx);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.mode  = m;
    req_ch.value = v;
    req_ch.index = idx;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic word_val_t pick_value(int unsigned stored_pct);
    int unsigned r;
    word_val_t   corners[7];
    corners = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0, -32'sh1, 32'sh1,
                32'sh8000_0001, 32'sh7fff_fffe};
    r = $urandom_range(99);
    if (r < stored_pct && sb.n_stored > 0)
      return sb.stored_at($urandom_range(sb.n_stored - 1));
    r = $urandom_range(99);
    if (r < 10) return corners[$urandom_range(6)];
    if (r < 40) return word_val_t'($signed($urandom_range(400)) - 200);
    return word_val_t'($urandom);
  endfunction

  task automatic send_random(bit filling);
    int unsigned               r;
    ost_pkg::mode_t            m;
    word_val_t                 v;
    logic [ost_pkg::IDX_W-1:0] idx;
    r = $urandom_range(99);
    if (filling) begin
      if (r < 65) m = ost_pkg::MODE_ADD;
      else if (r < 75) m = ost_pkg::MODE_REMOVE;
      else if (r < 88) m = ost_pkg::MODE_CONTAINS;
      else m = ost_pkg::MODE_READ;
    end else begin
      if (r < 15) m = ost_pkg::MODE_ADD;
      else if (r < 75) m = ost_pkg::MODE_REMOVE;
      else if (r < 88) m = ost_pkg::MODE_CONTAINS;
      else m = ost_pkg::MODE_READ;
    end
    case (m)
      ost_pkg::MODE_ADD:    v = pick_value(filling ? 10 : 40);
      ost_pkg::MODE_REMOVE: v = pick_value(filling ? 60 : 85);
      default:              v = pick_value(50);
    endcase
    if ($urandom_range(99) < 70 && sb.n_stored > 0)
      idx = ost_pkg::IDX_W'($urandom_range(sb.n_stored - 1));
    else
      idx = ost_pkg::IDX_W'($urandom_range(63));
    send_word(m, v, idx);
  endtask

  initial begin
    rst_n        = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.mode  = '0;
    req_ch.value = '0;
    req_ch.index = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    hold_req     = 1'b0;
    cycle_count  = 0;
    sb           = new();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // empty table
    send_word(ost_pkg::MODE_READ,     32'sh0, 6'd0);
    send_word(ost_pkg::MODE_CONTAINS, 32'sh0, 6'd0);
    send_word(ost_pkg::MODE_REMOVE,   32'sh5, 6'd0);
    // extremes of the value field
    send_word(ost_pkg::MODE_ADD,      32'sh8000_0000, 6'd0);
    send_word(ost_pkg::MODE_ADD,      32'sh7fff_ffff, 6'd63);
    send_word(ost_pkg::MODE_ADD,      32'sh0, 6'd0);
    send_word(ost_pkg::MODE_ADD,      -32'sh1, 6'd0);
    send_word(ost_pkg::MODE_ADD,      32'sh1, 6'd0);
    // duplicate add
    send_word(ost_pkg::MODE_ADD,      32'sh7fff_ffff, 6'd0);
    send_word(ost_pkg::MODE_CONTAINS, 32'sh8000_0000, 6'd0);
    // one bit off from a stored value
    send_word(ost_pkg::MODE_CONTAINS, 32'sh7fff_fffe, 6'd0);
    send_word(ost_pkg::MODE_CONTAINS, -32'sh2, 6'd0);
    send_word(ost_pkg::MODE_READ,     32'sh0, 6'd0);
    send_word(ost_pkg::MODE_READ,     32'sh0, 6'd4);
    // read beyond count
    send_word(ost_pkg::MODE_READ,     32'sh0, 6'd5);
    send_word(ost_pkg::MODE_READ,     -32'sh1, 6'd63);
    // remove from the middle, the front and the back
    send_word(ost_pkg::MODE_REMOVE,   32'sh0, 6'd0);
    send_word(ost_pkg::MODE_READ,     32'sh0, 6'd2);
    send_word(ost_pkg::MODE_REMOVE,   32'sh8000_0000, 6'd0);
    send_word(ost_pkg::MODE_REMOVE,   32'sh1, 6'd0);
    send_word(ost_pkg::MODE_REMOVE,   32'sh0, 6'd0);
    send_word(ost_pkg::MODE_READ,     32'sh0, 6'd0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 54; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 54; end
        default: begin idle_pct = 8; stall_pct = 8; end
      endcase
      for (int k = 0; k < ITEMS_PER_PH; k++) begin
        // long receiver hold-off while the sender keeps offering words
        if (ph == 0 && k == 30) hold_req = 1'b1;
        send_random(((k / SEG_LEN) % 2) == 0);
      end
    end
    req_ch.valid = 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
hdl/ost_pkg.sv
hdl/ost_ifs.sv
hdl/ost_ram.sv
hdl/ost_datapath.sv
hdl/ost_ctrl.sv
hdl/ordered_set_table.sv
bench/ordered_set_table_tb.sv
